// ----- src/fpba_pkg.sv -----
// fpba_pkg: shared constants, codes and types of the fit policy block allocator
// used by every file under src; depends on nothing
`default_nettype none

package fpba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int KIND_W    = 1;
  localparam int BIDX_W    = 4;
  localparam int AMOUNT_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int SUM_W     = 20;
  localparam int MODE_W    = 2;
  localparam int BIU_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int EXT_W     = 32;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b1;

  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd0;
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

  localparam logic [BIU_W-1:0] BIU_RESET = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic shift;
    logic commit;
  } ctrl_t;

endpackage

`default_nettype wire

// ----- src/fpba_cell.sv -----
// fpba_cell: one block of the capacity row; holds its remaining capacity and
// refines the search token passed on to the next cell; depends on fpba_pkg
`default_nettype none

module fpba_cell #(
  parameter int INDEX     = 0,
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          shift,
  input  wire logic                          commit,
  input  wire logic                          is_load,
  input  wire logic                          active,
  input  wire logic [fpba_pkg::MODE_W-1:0]   mode,
  input  wire logic [fpba_pkg::BIDX_W-1:0]   load_idx,
  input  wire logic [SIZE_BITS-1:0]          amt,
  input  wire logic                          sub_en,
  input  wire logic                          found_in,
  input  wire logic [IDX_W-1:0]              pick_in,
  input  wire logic [SIZE_BITS-1:0]          pcap_in,
  output logic                               found_out,
  output logic [IDX_W-1:0]                   pick_out,
  output logic [SIZE_BITS-1:0]               pcap_out
);

  logic [SIZE_BITS-1:0] cap;
  logic                 fits;
  logic                 better;
  logic                 addr_hit;
  logic                 take;

  assign fits     = cap >= amt;
  assign addr_hit = {{(fpba_pkg::EXT_W - fpba_pkg::BIDX_W){1'b0}}, load_idx}
                    == fpba_pkg::EXT_W'(INDEX);

  always_comb begin
    case (mode)
      fpba_pkg::FIT_FIRST: better = 1'b0;
      fpba_pkg::FIT_WORST: better = cap > pcap_in;
      default:             better = cap < pcap_in;
    endcase
  end

  assign take = is_load ? addr_hit : (active && fits && (!found_in || better));

  // a load keeps the old capacity through the walk and writes the new one at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= '0;
    end else if (commit && is_load && addr_hit) begin
      cap <= amt;
    end else if (sub_en) begin
      cap <= cap - amt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      found_out <= found_in | take;
      pick_out  <= take ? IDX_W'(INDEX) : pick_in;
      pcap_out  <= take ? cap : pcap_in;
    end
  end

endmodule

`default_nettype wire

// ----- src/fpba_ctrl.sv -----
// fpba_ctrl: sequencer that walks one token down the cell row and then
// hands the result to the output register; depends on fpba_pkg
`default_nettype none

module fpba_ctrl #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire logic     out_free,
  output fpba_pkg::ctrl_t ctrl
);

  localparam int CNT_W = $clog2(NUM_BLOCKS);

  fpba_pkg::state_t state;
  fpba_pkg::state_t state_next;
  logic [CNT_W-1:0] cnt;
  logic             last;

  assign last = cnt == CNT_W'(NUM_BLOCKS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpba_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == fpba_pkg::S_SCAN) ? cnt + CNT_W'(1) : '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fpba_pkg::S_IDLE: if (accept) state_next = fpba_pkg::S_SCAN;
      fpba_pkg::S_SCAN: if (last) state_next = fpba_pkg::S_DONE;
      fpba_pkg::S_DONE: if (out_free) state_next = fpba_pkg::S_IDLE;
      default:          state_next = fpba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      fpba_pkg::S_IDLE: ctrl.busy = 1'b0;
      fpba_pkg::S_SCAN: begin
        ctrl.busy  = 1'b1;
        ctrl.shift = 1'b1;
      end
      fpba_pkg::S_DONE: begin
        ctrl.busy   = 1'b1;
        ctrl.commit = out_free;
      end
      default: ctrl = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/fit_policy_block_allocator.sv -----
// fit_policy_block_allocator: top level with config registers, cell row,
// sequencer and result register; depends on fpba_pkg, fpba_cell, fpba_ctrl
//
// Keeps the remaining capacity of NUM_BLOCKS blocks, one per cell of a row.
// Every item (load or allocate) enters as a token that walks the row one cell
// per cycle: a load writes the addressed cell and picks up its old capacity,
// an allocate keeps the best candidate under the current fit mode. An item
// passes from the accept state through the token walk along the whole cell
// row to the commit state, which waits for a free output register; no new
// item is taken before it leaves. The result sits in an output register, so a
// new item is taken while the previous result still waits. All capacities
// and the free total are cleared by reset. Configuration writes are always
// ready and should be made while no item is in flight.
`default_nettype none

module fit_policy_block_allocator #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fpba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fpba_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic [fpba_pkg::KIND_W-1:0]      kind,
  input  wire logic [fpba_pkg::BIDX_W-1:0]      block_index,
  input  wire logic [fpba_pkg::AMOUNT_W-1:0]    amount,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [fpba_pkg::STATUS_W-1:0]         status,
  output logic [fpba_pkg::BIDX_W-1:0]           chosen_block,
  output logic [fpba_pkg::AMOUNT_W-1:0]         block_remaining,
  output logic [fpba_pkg::SUM_W-1:0]            total_free
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int EXT_W = fpba_pkg::EXT_W;

  fpba_pkg::ctrl_t ctrl;

  logic [fpba_pkg::MODE_W-1:0] fit_mode;
  logic [fpba_pkg::BIU_W-1:0]  blocks_in_use;
  logic [fpba_pkg::SUM_W-1:0]  free_sum;

  logic                        accept;
  logic                        out_free;
  logic [EXT_W-1:0]            amount_ext;
  logic [fpba_pkg::KIND_W-1:0] kind_q;
  logic [fpba_pkg::BIDX_W-1:0] idx_q;
  logic [SIZE_BITS-1:0]        amt_q;
  logic                        is_load;

  logic                 found_c [NUM_BLOCKS+1];
  logic [IDX_W-1:0]     pick_c  [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] pcap_c  [NUM_BLOCKS+1];
  logic [NUM_BLOCKS-1:0] active;
  logic [NUM_BLOCKS-1:0] sub_en;

  logic [EXT_W-1:0]            pick_ext;
  logic [EXT_W-1:0]            pcap_ext;
  logic [EXT_W-1:0]            amt_ext;
  logic [EXT_W-1:0]            sum_ext;
  logic [EXT_W-1:0]            load_sum;
  logic [EXT_W-1:0]            alloc_sum;
  logic [EXT_W-1:0]            alloc_rem;
  logic [fpba_pkg::STATUS_W-1:0] status_next;
  logic [fpba_pkg::BIDX_W-1:0]   chosen_next;
  logic [fpba_pkg::AMOUNT_W-1:0] remaining_next;
  logic [fpba_pkg::SUM_W-1:0]    free_sum_next;

  assign cfg_ready  = 1'b1;
  assign item_stall = ctrl.busy;
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign amount_ext = {{(EXT_W - fpba_pkg::AMOUNT_W){1'b0}}, amount};
  assign is_load    = kind_q == fpba_pkg::KIND_LOAD;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= fpba_pkg::FIT_BEST;
      blocks_in_use <= fpba_pkg::BIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpba_pkg::CFG_FIT_MODE:      fit_mode <= cfg_data[fpba_pkg::MODE_W-1:0];
        fpba_pkg::CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[fpba_pkg::BIU_W-1:0];
        default:                     fit_mode <= fit_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      idx_q  <= block_index;
      amt_q  <= amount_ext[SIZE_BITS-1:0];
    end
  end

  fpba_ctrl #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign found_c[0] = 1'b0;
  assign pick_c[0]  = '0;
  assign pcap_c[0]  = '0;

  for (genvar j = 0; j < NUM_BLOCKS; j++) begin : g_cell
    assign active[j] = EXT_W'(j) <
                       {{(EXT_W - fpba_pkg::BIU_W){1'b0}}, blocks_in_use};
    assign sub_en[j] = ctrl.commit && !is_load && found_c[NUM_BLOCKS] &&
                       (pick_c[NUM_BLOCKS] == IDX_W'(j));

    fpba_cell #(
      .INDEX     (j),
      .IDX_W     (IDX_W),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (ctrl.shift),
      .commit    (ctrl.commit),
      .is_load   (is_load),
      .active    (active[j]),
      .mode      (fit_mode),
      .load_idx  (idx_q),
      .amt       (amt_q),
      .sub_en    (sub_en[j]),
      .found_in  (found_c[j]),
      .pick_in   (pick_c[j]),
      .pcap_in   (pcap_c[j]),
      .found_out (found_c[j+1]),
      .pick_out  (pick_c[j+1]),
      .pcap_out  (pcap_c[j+1])
    );
  end

  assign pick_ext  = EXT_W'(pick_c[NUM_BLOCKS]);
  assign pcap_ext  = EXT_W'(pcap_c[NUM_BLOCKS]);
  assign amt_ext   = EXT_W'(amt_q);
  assign sum_ext   = EXT_W'(free_sum);
  assign load_sum  = sum_ext + amt_ext - pcap_ext;
  assign alloc_sum = sum_ext - amt_ext;
  assign alloc_rem = pcap_ext - amt_ext;

  always_comb begin
    status_next    = fpba_pkg::ST_LOADED;
    chosen_next    = idx_q;
    remaining_next = '0;
    free_sum_next  = free_sum;
    if (is_load) begin
      if (found_c[NUM_BLOCKS]) begin
        remaining_next = amt_ext[fpba_pkg::AMOUNT_W-1:0];
        free_sum_next  = load_sum[fpba_pkg::SUM_W-1:0];
      end
    end else if (found_c[NUM_BLOCKS]) begin
      status_next    = fpba_pkg::ST_ALLOCATED;
      chosen_next    = pick_ext[fpba_pkg::BIDX_W-1:0];
      remaining_next = alloc_rem[fpba_pkg::AMOUNT_W-1:0];
      free_sum_next  = alloc_sum[fpba_pkg::SUM_W-1:0];
    end else begin
      status_next = fpba_pkg::ST_NO_FIT;
      chosen_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_sum     <= '0;
      result_valid <= 1'b0;
    end else if (ctrl.commit) begin
      free_sum     <= free_sum_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      status          <= status_next;
      chosen_block    <= chosen_next;
      block_remaining <= remaining_next;
      total_free      <= free_sum_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/fpba_checker.sv -----
// fpba_checker: port-level assertions for the fit policy block allocator,
// bound to the top level; depends on fpba_pkg and fit_policy_block_allocator
`default_nettype none

module fpba_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           item_valid,
  input wire logic                           item_stall,
  input wire logic                           result_valid,
  input wire logic                           result_stall,
  input wire logic [fpba_pkg::STATUS_W-1:0]  status,
  input wire logic [fpba_pkg::BIDX_W-1:0]    chosen_block,
  input wire logic [fpba_pkg::AMOUNT_W-1:0]  block_remaining,
  input wire logic [fpba_pkg::SUM_W-1:0]     total_free
);

  // an accepted item keeps the input side busy while it walks the row
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input not stalled after item transfer");

  // a new result only appears at the end of an item's work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without an item in flight");

  a_no_fit_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == fpba_pkg::ST_NO_FIT |->
      chosen_block == '0 && block_remaining == '0)
    else $error("no-fit result carries a block or capacity");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(status) && $stable(chosen_block) &&
      $stable(block_remaining) && $stable(total_free))
    else $error("stalled result changed");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item_valid),
  .item_stall      (item_stall),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .status          (status),
  .chosen_block    (chosen_block),
  .block_remaining (block_remaining),
  .total_free      (total_free)
);

`default_nettype wire
